>>> rtl/core/bvp_pkg.sv
// ----------------------------------------------------------------------------
// bvp_pkg
// Shared types and codes for the battery voltage protection core.
// ----------------------------------------------------------------------------
`default_nettype none

package bvp_pkg;

  localparam int unsigned VW = 16;  // voltage / time width

  // mode codes
  localparam logic [2:0] MODE_INIT   = 3'd0;
  localparam logic [2:0] MODE_NORMAL = 3'd1;
  localparam logic [2:0] MODE_LOW    = 3'd2;
  localparam logic [2:0] MODE_HIGH   = 3'd3;
  localparam logic [2:0] MODE_UNDER  = 3'd4;
  localparam logic [2:0] MODE_OVER   = 3'd5;

  // pending action / protect event codes
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_UNDER   = 2'd1;
  localparam logic [1:0] ACT_OVER    = 2'd2;
  localparam logic [1:0] ACT_RECOVER = 2'd3;

  // register indexes
  localparam logic [2:0] REG_LOW_LIMIT     = 3'd0;
  localparam logic [2:0] REG_HIGH_LIMIT    = 3'd1;
  localparam logic [2:0] REG_LOW_RCV       = 3'd2;
  localparam logic [2:0] REG_HIGH_RCV      = 3'd3;
  localparam logic [2:0] REG_UNDER_ENTRY   = 3'd4;
  localparam logic [2:0] REG_OVER_ENTRY    = 3'd5;
  localparam logic [2:0] REG_UNDER_RCV_T   = 3'd6;
  localparam logic [2:0] REG_OVER_RCV_T    = 3'd7;

  // register reset values
  localparam logic [VW-1:0] RST_LOW_LIMIT   = 16'd9000;
  localparam logic [VW-1:0] RST_HIGH_LIMIT  = 16'd16000;
  localparam logic [VW-1:0] RST_LOW_RCV     = 16'd9500;
  localparam logic [VW-1:0] RST_HIGH_RCV    = 16'd15500;
  localparam logic [VW-1:0] RST_DWELL       = 16'd1000;

  typedef struct packed {
    logic [VW-1:0] low_limit;
    logic [VW-1:0] high_limit;
    logic [VW-1:0] low_rcv;
    logic [VW-1:0] high_rcv;
    logic [VW-1:0] under_entry;
    logic [VW-1:0] over_entry;
    logic [VW-1:0] under_rcv_t;
    logic [VW-1:0] over_rcv_t;
  } bvp_cfg_t;

  typedef struct packed {
    logic [2:0]    mode;
    logic [1:0]    pending;
    logic [VW-1:0] low_ret;
    logic [VW-1:0] low_esc;
    logic [VW-1:0] high_ret;
    logic [VW-1:0] high_esc;
    logic [VW-1:0] under_exit;
    logic [VW-1:0] over_exit;
    logic [1:0]    err_flags;  // bit 0 low, bit 1 high
  } bvp_state_t;

  typedef struct packed {
    logic       high_error_flag;
    logic       low_error_flag;
    logic       recover_event;
    logic [1:0] protect_event;
    logic [2:0] mode_code;
  } bvp_result_t;

  // add with saturation at all-ones
  function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VW] ? {VW{1'b1}} : s[VW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/bvp_step.sv
// ----------------------------------------------------------------------------
// bvp_step
// Next-state and result logic for one tick of the protection state machine.
// ----------------------------------------------------------------------------
`default_nettype none

module bvp_step import bvp_pkg::*; #(
  parameter int unsigned LOW_RETURN_TIME  = 100,
  parameter int unsigned HIGH_RETURN_TIME = 100
) (
  input  bvp_state_t      state_i,
  input  bvp_cfg_t        cfg_i,
  input  logic [VW-1:0]   level_i,
  input  logic [VW-1:0]   elapsed_i,
  output bvp_state_t      state_o,
  output bvp_result_t     result_o
);

  localparam logic [VW-1:0] LowRetT  = VW'(LOW_RETURN_TIME);
  localparam logic [VW-1:0] HighRetT = VW'(HIGH_RETURN_TIME);

  always_comb begin
    bvp_state_t n;
    logic [1:0] protect;
    logic       recover;
    n       = state_i;
    protect = ACT_NONE;
    recover = 1'b0;

    case (state_i.mode)
      MODE_INIT: begin
        n.mode       = MODE_NORMAL;
        n.pending    = ACT_NONE;
        n.low_ret    = '0;
        n.low_esc    = '0;
        n.high_ret   = '0;
        n.high_esc   = '0;
        n.under_exit = '0;
        n.over_exit  = '0;
      end
      MODE_NORMAL: begin
        n.low_ret    = '0;
        n.low_esc    = '0;
        n.high_ret   = '0;
        n.high_esc   = '0;
        n.under_exit = '0;
        n.over_exit  = '0;
        if (level_i < cfg_i.low_limit) begin
          n.mode = MODE_LOW;
        end else if (level_i > cfg_i.high_limit) begin
          n.mode = MODE_HIGH;
        end
        if (state_i.pending == ACT_RECOVER) begin
          recover   = 1'b1;
          n.pending = ACT_NONE;
        end
      end
      MODE_LOW: begin
        n.high_ret   = '0;
        n.high_esc   = '0;
        n.under_exit = '0;
        n.over_exit  = '0;
        if (level_i >= cfg_i.low_limit) begin
          n.low_ret = sat_add(state_i.low_ret, elapsed_i);
          n.low_esc = '0;
        end else begin
          n.low_ret = '0;
          n.low_esc = sat_add(state_i.low_esc, elapsed_i);
        end
        if (n.low_ret >= LowRetT) begin
          n.low_ret = LowRetT;
          n.mode    = MODE_NORMAL;
        end
        // escalation checked last and wins
        if (n.low_esc >= cfg_i.under_entry) begin
          n.low_esc = cfg_i.under_entry;
          n.mode    = MODE_UNDER;
          n.pending = ACT_UNDER;
        end
      end
      MODE_HIGH: begin
        n.low_ret    = '0;
        n.low_esc    = '0;
        n.under_exit = '0;
        n.over_exit  = '0;
        if (level_i <= cfg_i.high_limit) begin
          n.high_ret = sat_add(state_i.high_ret, elapsed_i);
          n.high_esc = '0;
        end else begin
          n.high_ret = '0;
          n.high_esc = sat_add(state_i.high_esc, elapsed_i);
        end
        if (n.high_ret >= HighRetT) begin
          n.high_ret = HighRetT;
          n.mode     = MODE_NORMAL;
        end
        if (n.high_esc >= cfg_i.over_entry) begin
          n.high_esc = cfg_i.over_entry;
          n.mode     = MODE_OVER;
          n.pending  = ACT_OVER;
        end
      end
      MODE_UNDER: begin
        n.low_ret   = '0;
        n.high_ret  = '0;
        n.low_esc   = '0;
        n.high_esc  = '0;
        n.over_exit = '0;
        n.under_exit = (level_i >= cfg_i.low_rcv) ?
                       sat_add(state_i.under_exit, elapsed_i) : '0;
        if (n.under_exit >= cfg_i.under_rcv_t) begin
          n.under_exit = cfg_i.under_rcv_t;
          n.mode       = MODE_NORMAL;
          n.pending    = ACT_RECOVER;
        end
        // immediate recovery overwrites the pending protect action
        if (n.pending == ACT_UNDER) begin
          protect        = ACT_UNDER;
          n.pending      = ACT_NONE;
          n.err_flags[0] = 1'b1;
        end
      end
      MODE_OVER: begin
        n.low_ret    = '0;
        n.high_ret   = '0;
        n.low_esc    = '0;
        n.high_esc   = '0;
        n.under_exit = '0;
        n.over_exit  = (level_i <= cfg_i.high_rcv) ?
                       sat_add(state_i.over_exit, elapsed_i) : '0;
        if (n.over_exit >= cfg_i.over_rcv_t) begin
          n.over_exit = cfg_i.over_rcv_t;
          n.mode      = MODE_NORMAL;
          n.pending   = ACT_RECOVER;
        end
        if (n.pending == ACT_OVER) begin
          protect        = ACT_OVER;
          n.pending      = ACT_NONE;
          n.err_flags[1] = 1'b1;
        end
      end
      default: begin
        // unused mode codes: back to normal, pending action kept
        n.mode       = MODE_NORMAL;
        n.low_ret    = '0;
        n.low_esc    = '0;
        n.high_ret   = '0;
        n.high_esc   = '0;
        n.under_exit = '0;
        n.over_exit  = '0;
      end
    endcase

    state_o                  = n;
    result_o.mode_code       = n.mode;
    result_o.protect_event   = protect;
    result_o.recover_event   = recover;
    result_o.low_error_flag  = n.err_flags[0];
    result_o.high_error_flag = n.err_flags[1];
  end

endmodule

`default_nettype wire

>>> rtl/core/battery_voltage_protection_fsm_core.sv
// ----------------------------------------------------------------------------
// battery_voltage_protection_fsm_core
// Battery under/overvoltage monitor with debounced pending states.
// ----------------------------------------------------------------------------
// Result path: the request is captured in the input register at the accept
//   edge and evaluated into the result register once that register is free.
// Throughput: one request per cycle unless the result stream stalls.
// Reset (rst_ni low, async): mode init, timers, pending action and sticky
//   flags cleared, limit registers back to their defaults, both stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_voltage_protection_fsm_core import bvp_pkg::*; #(
  parameter int unsigned LOW_RETURN_TIME  = 100,
  parameter int unsigned HIGH_RETURN_TIME = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] battery_level, [31:16] elapsed_time
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [2:0] mode_code, [4:3] protect_event,
                                      // [5] recover_event, [6] low_error_flag,
                                      // [7] high_error_flag
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // --------------------------------------------------------------------------
  // Register file: eight 16-bit registers at 4-byte spacing.
  // --------------------------------------------------------------------------
  bvp_cfg_t   cfg_q;
  logic [2:0] reg_idx;
  logic       reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_limit   <= RST_LOW_LIMIT;
      cfg_q.high_limit  <= RST_HIGH_LIMIT;
      cfg_q.low_rcv     <= RST_LOW_RCV;
      cfg_q.high_rcv    <= RST_HIGH_RCV;
      cfg_q.under_entry <= RST_DWELL;
      cfg_q.over_entry  <= RST_DWELL;
      cfg_q.under_rcv_t <= RST_DWELL;
      cfg_q.over_rcv_t  <= RST_DWELL;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_LOW_LIMIT:   cfg_q.low_limit   <= pwdata[VW-1:0];
        REG_HIGH_LIMIT:  cfg_q.high_limit  <= pwdata[VW-1:0];
        REG_LOW_RCV:     cfg_q.low_rcv     <= pwdata[VW-1:0];
        REG_HIGH_RCV:    cfg_q.high_rcv    <= pwdata[VW-1:0];
        REG_UNDER_ENTRY: cfg_q.under_entry <= pwdata[VW-1:0];
        REG_OVER_ENTRY:  cfg_q.over_entry  <= pwdata[VW-1:0];
        REG_UNDER_RCV_T: cfg_q.under_rcv_t <= pwdata[VW-1:0];
        REG_OVER_RCV_T:  cfg_q.over_rcv_t  <= pwdata[VW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [VW-1:0] rd;
    case (reg_idx)
      REG_LOW_LIMIT:   rd = cfg_q.low_limit;
      REG_HIGH_LIMIT:  rd = cfg_q.high_limit;
      REG_LOW_RCV:     rd = cfg_q.low_rcv;
      REG_HIGH_RCV:    rd = cfg_q.high_rcv;
      REG_UNDER_ENTRY: rd = cfg_q.under_entry;
      REG_OVER_ENTRY:  rd = cfg_q.over_entry;
      REG_UNDER_RCV_T: rd = cfg_q.under_rcv_t;
      REG_OVER_RCV_T:  rd = cfg_q.over_rcv_t;
      default:         rd = '0;
    endcase
    prdata = {16'd0, rd};
  end

  // --------------------------------------------------------------------------
  // Pipeline control. Stage 1 holds the accepted request; it is evaluated
  // and folded into the state as it moves into the result register.
  // --------------------------------------------------------------------------
  logic          in_vld_q;
  logic [VW-1:0] level_q;
  logic [VW-1:0] elapsed_q;
  logic          out_vld_q;
  bvp_result_t   res_q;
  bvp_state_t    st_q;
  bvp_state_t    st_d;
  bvp_result_t   res_d;
  logic          out_free;
  logic          advance;
  logic          in_take;

  assign out_free      = ~out_vld_q | m_axis_tready;
  assign advance       = in_vld_q & out_free;
  assign s_axis_tready = ~in_vld_q | out_free;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      level_q   <= s_axis_tdata[15:0];
      elapsed_q <= s_axis_tdata[31:16];
    end
  end

  // tick evaluation
  bvp_step #(
    .LOW_RETURN_TIME  (LOW_RETURN_TIME),
    .HIGH_RETURN_TIME (HIGH_RETURN_TIME)
  ) u_step (
    .state_i   (st_q),
    .cfg_i     (cfg_q),
    .level_i   (level_q),
    .elapsed_i (elapsed_q),
    .state_o   (st_d),
    .result_o  (res_d)
  );

  // monitor state: init mode, all timers and flags clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{mode: MODE_INIT, pending: ACT_NONE, default: '0};
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;

endmodule

`default_nettype wire

>>> rtl/core/bvp_checker.sv
// ----------------------------------------------------------------------------
// bvp_checker
// Port-level checks on the result stream of the protection core.
// ----------------------------------------------------------------------------
`default_nettype none

module bvp_checker import bvp_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  logic [2:0] mode;
  logic [1:0] prot;
  logic       rcv;
  logic       out_take;
  logic [1:0] flags_seen_q;

  assign mode     = m_axis_tdata[2:0];
  assign prot     = m_axis_tdata[4:3];
  assign rcv      = m_axis_tdata[5];
  assign out_take = m_axis_tvalid & m_axis_tready;

  // sticky flags seen on delivered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_seen_q <= 2'b00;
    end else if (out_take) begin
      flags_seen_q <= flags_seen_q | m_axis_tdata[7:6];
    end
  end

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  a_protect_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (prot == ACT_NONE) ||
                      (prot == ACT_UNDER && mode == MODE_UNDER && m_axis_tdata[6]) ||
                      (prot == ACT_OVER && mode == MODE_OVER && m_axis_tdata[7]))
    else $error("protect event inconsistent with mode or flag");

  a_recover_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && rcv |-> (mode == MODE_NORMAL) || (mode == MODE_LOW) ||
                             (mode == MODE_HIGH))
    else $error("recover event outside normal tick");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[7:6] & flags_seen_q) == flags_seen_q))
    else $error("sticky error flag cleared");

endmodule

bind battery_voltage_protection_fsm_core bvp_checker u_bvp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
